// ----- design/tcts_pkg.sv -----
// ----------------------------------------------------------------------------
// tcts_pkg
// Shared types, codes and defaults of the three-class task scheduler.
// ----------------------------------------------------------------------------
package tcts_pkg;

  localparam int PRIO_DEPTH_DEF = 16;
  localparam int RR_DEPTH_DEF   = 16;
  localparam int SLOT_DEPTH_DEF = 16;

  localparam logic [7:0] WINDOW_RESET = 8'd60;
  localparam logic [7:0] LIMIT_RESET  = 8'd3;

  // Event codes of a response.
  localparam logic [2:0] EV_IDLE    = 3'd0;
  localparam logic [2:0] EV_RT      = 3'd1;
  localparam logic [2:0] EV_PRIO    = 3'd2;
  localparam logic [2:0] EV_RR      = 3'd3;
  localparam logic [2:0] EV_ADMIT   = 3'd4;
  localparam logic [2:0] EV_WINDOW  = 3'd5;
  localparam logic [2:0] EV_OVERLAP = 3'd6;
  localparam logic [2:0] EV_FULL    = 3'd7;

  // Task classes.
  localparam logic [1:0] CLS_PRIO   = 2'd0;
  localparam logic [1:0] CLS_RR     = 2'd1;
  localparam logic [1:0] CLS_RT     = 2'd2;
  localparam logic [1:0] CLS_UNUSED = 2'd3;

  // Function codes.
  localparam logic FN_ADMIT = 1'b0;
  localparam logic FN_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  // Datapath operations issued by the controller.
  typedef logic [4:0] op_t;
  localparam op_t OP_NOP         = 5'd0;
  localparam op_t OP_LOAD        = 5'd1;
  localparam op_t OP_RES_FULL    = 5'd2;
  localparam op_t OP_RES_WINDOW  = 5'd3;
  localparam op_t OP_RES_OVERLAP = 5'd4;
  localparam op_t OP_RES_IDLE    = 5'd5;
  localparam op_t OP_RR_APPEND   = 5'd6;
  localparam op_t OP_PI_START    = 5'd7;
  localparam op_t OP_PI_READ     = 5'd8;
  localparam op_t OP_PI_SHIFT    = 5'd9;
  localparam op_t OP_PI_PLACE    = 5'd10;
  localparam op_t OP_SCAN_START  = 5'd11;
  localparam op_t OP_S_READ_K    = 5'd12;
  localparam op_t OP_K_INC       = 5'd13;
  localparam op_t OP_SI_START    = 5'd14;
  localparam op_t OP_SI_READ     = 5'd15;
  localparam op_t OP_SI_SHIFT    = 5'd16;
  localparam op_t OP_SI_PLACE    = 5'd17;
  localparam op_t OP_RES_SLOT    = 5'd18;
  localparam op_t OP_P_READ_HEAD = 5'd19;
  localparam op_t OP_P_POP       = 5'd20;
  localparam op_t OP_R_READ_HEAD = 5'd21;
  localparam op_t OP_R_ROTATE    = 5'd22;

  typedef struct packed {
    logic       func;
    logic [1:0] cls;
    logic       prio_full;
    logic       rr_full;
    logic       slot_full;
    logic       prio_empty;
    logic       rr_empty;
    logic       window_bad;
    logic       prem_zero;
    logic       sidx_zero;
    logic       sidx_end;
    logic       overlap;
    logic       start_gt;
    logic       level_gt;
    logic       slot_hit;
    logic       retire;
  } stat_t;

  typedef struct packed {
    logic [7:0]  cnt;
    logic [7:0]  level;
    logic [15:0] id;
  } pent_t;

  typedef struct packed {
    logic [5:0]  len;
    logic [5:0]  start;
    logic [15:0] id;
  } sent_t;

endpackage

// ----- design/tcts_if.sv -----
// ----------------------------------------------------------------------------
// tcts_if
// Request, response and configuration channels of the task scheduler.
// ----------------------------------------------------------------------------
interface tcts_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [15:0] task_id;
  logic [1:0] task_class;
  logic [7:0] priority_level;
  logic [5:0] start_second;
  logic [5:0] run_length;
  logic [5:0] current_second;

  modport source (output valid, func, task_id, task_class, priority_level,
                  start_second, run_length, current_second, input ready);
  modport sink (input valid, func, task_id, task_class, priority_level,
                start_second, run_length, current_second, output ready);
endinterface

interface tcts_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_code;
  logic [15:0] run_task_id;
  logic [5:0]  run_quanta;
  logic        task_retired;

  modport source (output valid, event_code, run_task_id, run_quanta, task_retired,
                  input ready);
  modport sink (input valid, event_code, run_task_id, run_quanta, task_retired,
                output ready);
endinterface

interface tcts_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/tcts_dpath.sv -----
// ----------------------------------------------------------------------------
// tcts_dpath
// Queue memories, walk pointers, configuration and result registers.
// ----------------------------------------------------------------------------
module tcts_dpath #(
  parameter int PRIO_DEPTH = tcts_pkg::PRIO_DEPTH_DEF,
  parameter int RR_DEPTH   = tcts_pkg::RR_DEPTH_DEF,
  parameter int SLOT_DEPTH = tcts_pkg::SLOT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  tcts_pkg::op_t      op,
  output tcts_pkg::stat_t    stat,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_func,
  input  logic [15:0]        in_id,
  input  logic [1:0]         in_cls,
  input  logic [7:0]         in_level,
  input  logic [5:0]         in_start,
  input  logic [5:0]         in_len,
  input  logic [5:0]         in_now,
  output logic [2:0]         res_code,
  output logic [15:0]        res_id,
  output logic [5:0]         res_quanta,
  output logic               res_retired
);

  localparam int PIW = (PRIO_DEPTH > 1) ? $clog2(PRIO_DEPTH) : 1;
  localparam int PFW = $clog2(PRIO_DEPTH + 1);
  localparam int RIW = (RR_DEPTH > 1) ? $clog2(RR_DEPTH) : 1;
  localparam int RFW = $clog2(RR_DEPTH + 1);
  localparam int SIW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int SFW = $clog2(SLOT_DEPTH + 1);

  localparam logic [PIW-1:0] PLAST = PIW'(PRIO_DEPTH - 1);
  localparam logic [RIW-1:0] RLAST = RIW'(RR_DEPTH - 1);

  // Latched request.
  logic        it_func;
  logic [15:0] it_id;
  logic [1:0]  it_cls;
  logic [7:0]  it_level;
  logic [5:0]  it_start;
  logic [5:0]  it_len;
  logic [5:0]  it_now;

  logic [7:0] window;
  logic [7:0] limit;

  // Priority queue: circular buffer kept sorted from head to tail.
  tcts_pkg::pent_t pmem [PRIO_DEPTH];
  tcts_pkg::pent_t prd;
  tcts_pkg::pent_t nent;
  logic [PIW-1:0]  phead, ptail, pwp;
  logic [PFW-1:0]  pfill, prem;

  // Round-robin queue: circular buffer.
  logic [15:0]    rmem [RR_DEPTH];
  logic [15:0]    rrd;
  logic [RIW-1:0] rhead, rtail;
  logic [RFW-1:0] rfill;

  // Real-time slots: sorted by start, from index zero.
  tcts_pkg::sent_t smem [SLOT_DEPTH];
  tcts_pkg::sent_t srd;
  logic [SFW-1:0]  sfill, sidx;
  logic [SFW-1:0]  sidx_m1;

  logic [PIW-1:0] pwp_dec, phead_inc, ptail_inc;
  logic [RIW-1:0] rhead_inc, rtail_inc;
  logic [7:0]     cnt_sat;
  logic [6:0]     new_end, old_end;

  logic            pwe, pre;
  logic [PIW-1:0]  praddr;
  tcts_pkg::pent_t pwdata;
  logic            rwe;
  logic [15:0]     rwdata;
  logic            swe, sre;
  logic [SIW-1:0]  sraddr;
  tcts_pkg::sent_t swdata;

  always_comb begin
    pwp_dec   = (pwp == '0) ? PLAST : pwp - 1'b1;
    phead_inc = (phead == PLAST) ? '0 : phead + 1'b1;
    ptail_inc = (ptail == PLAST) ? '0 : ptail + 1'b1;
    rhead_inc = (rhead == RLAST) ? '0 : rhead + 1'b1;
    rtail_inc = (rtail == RLAST) ? '0 : rtail + 1'b1;
    sidx_m1   = sidx - 1'b1;
    cnt_sat   = (prd.cnt == 8'hFF) ? 8'hFF : prd.cnt + 8'd1;
    new_end   = {1'b0, it_start} + {1'b0, it_len};
    old_end   = {1'b0, srd.start} + {1'b0, srd.len};
  end

  always_comb begin
    stat.func       = it_func;
    stat.cls        = it_cls;
    stat.prio_full  = (pfill == PFW'(PRIO_DEPTH));
    stat.rr_full    = (rfill == RFW'(RR_DEPTH));
    stat.slot_full  = (sfill == SFW'(SLOT_DEPTH));
    stat.prio_empty = (pfill == '0);
    stat.rr_empty   = (rfill == '0);
    stat.window_bad = ({1'b0, new_end} > window);
    stat.prem_zero  = (prem == '0);
    stat.sidx_zero  = (sidx == '0);
    stat.sidx_end   = (sidx == sfill);
    stat.overlap    = !((new_end <= {1'b0, srd.start}) || (old_end <= {1'b0, it_start}));
    stat.start_gt   = (srd.start > it_start);
    stat.level_gt   = (prd.level > nent.level);
    stat.slot_hit   = (srd.start == it_now);
    stat.retire     = (cnt_sat >= limit);
  end

  // Memory port controls.
  always_comb begin
    pwe    = (op == tcts_pkg::OP_PI_SHIFT) || (op == tcts_pkg::OP_PI_PLACE);
    pwdata = (op == tcts_pkg::OP_PI_SHIFT) ? prd : nent;
    pre    = (op == tcts_pkg::OP_PI_READ) || (op == tcts_pkg::OP_P_READ_HEAD);
    praddr = (op == tcts_pkg::OP_P_READ_HEAD) ? phead : pwp_dec;
    rwe    = (op == tcts_pkg::OP_RR_APPEND) || (op == tcts_pkg::OP_R_ROTATE);
    rwdata = (op == tcts_pkg::OP_RR_APPEND) ? it_id : rrd;
    swe    = (op == tcts_pkg::OP_SI_SHIFT) || (op == tcts_pkg::OP_SI_PLACE);
    swdata = (op == tcts_pkg::OP_SI_SHIFT) ? srd : {it_len, it_start, it_id};
    sre    = (op == tcts_pkg::OP_S_READ_K) || (op == tcts_pkg::OP_SI_READ);
    sraddr = (op == tcts_pkg::OP_SI_READ) ? sidx_m1[SIW-1:0] : sidx[SIW-1:0];
  end

  always_ff @(posedge clk) begin
    if (pwe) begin
      pmem[pwp] <= pwdata;
    end
    if (pre) begin
      prd <= pmem[praddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rwe) begin
      rmem[rtail] <= rwdata;
    end
    if (op == tcts_pkg::OP_R_READ_HEAD) begin
      rrd <= rmem[rhead];
    end
  end

  always_ff @(posedge clk) begin
    if (swe) begin
      smem[sidx[SIW-1:0]] <= swdata;
    end
    if (sre) begin
      srd <= smem[sraddr];
    end
  end

  // Control state: fills, pointers and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      phead  <= '0;
      ptail  <= '0;
      pfill  <= '0;
      rhead  <= '0;
      rtail  <= '0;
      rfill  <= '0;
      sfill  <= '0;
      window <= tcts_pkg::WINDOW_RESET;
      limit  <= tcts_pkg::LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == tcts_pkg::CFG_WINDOW) begin
          window <= cfg_data;
        end else begin
          limit <= cfg_data;
        end
      end
      case (op)
        tcts_pkg::OP_PI_PLACE: begin
          ptail <= ptail_inc;
          pfill <= pfill + 1'b1;
        end
        tcts_pkg::OP_P_POP: begin
          phead <= phead_inc;
          pfill <= pfill - 1'b1;
        end
        tcts_pkg::OP_RR_APPEND: begin
          rtail <= rtail_inc;
          rfill <= rfill + 1'b1;
        end
        tcts_pkg::OP_R_ROTATE: begin
          rhead <= rhead_inc;
          rtail <= rtail_inc;
        end
        tcts_pkg::OP_SI_PLACE: begin
          sfill <= sfill + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Request latch, walk registers and result.
  always_ff @(posedge clk) begin
    case (op)
      tcts_pkg::OP_LOAD: begin
        it_func  <= in_func;
        it_id    <= in_id;
        it_cls   <= in_cls;
        it_level <= in_level;
        it_start <= in_start;
        it_len   <= in_len;
        it_now   <= in_now;
      end
      tcts_pkg::OP_RES_FULL: begin
        res_code    <= tcts_pkg::EV_FULL;
        res_id      <= '0;
        res_quanta  <= '0;
        res_retired <= 1'b0;
      end
      tcts_pkg::OP_RES_WINDOW: begin
        res_code    <= tcts_pkg::EV_WINDOW;
        res_id      <= '0;
        res_quanta  <= '0;
        res_retired <= 1'b0;
      end
      tcts_pkg::OP_RES_OVERLAP: begin
        res_code    <= tcts_pkg::EV_OVERLAP;
        res_id      <= '0;
        res_quanta  <= '0;
        res_retired <= 1'b0;
      end
      tcts_pkg::OP_RES_IDLE: begin
        res_code    <= tcts_pkg::EV_IDLE;
        res_id      <= '0;
        res_quanta  <= '0;
        res_retired <= 1'b0;
      end
      tcts_pkg::OP_RR_APPEND: begin
        res_code    <= tcts_pkg::EV_ADMIT;
        res_id      <= '0;
        res_quanta  <= '0;
        res_retired <= 1'b0;
      end
      tcts_pkg::OP_PI_START: begin
        nent        <= {{2'b00, it_len}, it_level, it_id};
        pwp         <= ptail;
        prem        <= pfill;
        res_code    <= tcts_pkg::EV_ADMIT;
        res_id      <= '0;
        res_quanta  <= '0;
        res_retired <= 1'b0;
      end
      tcts_pkg::OP_PI_SHIFT: begin
        pwp  <= pwp_dec;
        prem <= prem - 1'b1;
      end
      tcts_pkg::OP_SCAN_START: begin
        sidx <= '0;
      end
      tcts_pkg::OP_K_INC: begin
        sidx <= sidx + 1'b1;
      end
      tcts_pkg::OP_SI_START: begin
        sidx        <= sfill;
        res_code    <= tcts_pkg::EV_ADMIT;
        res_id      <= '0;
        res_quanta  <= '0;
        res_retired <= 1'b0;
      end
      tcts_pkg::OP_SI_SHIFT: begin
        sidx <= sidx_m1;
      end
      tcts_pkg::OP_RES_SLOT: begin
        res_code    <= tcts_pkg::EV_RT;
        res_id      <= srd.id;
        res_quanta  <= srd.len;
        res_retired <= 1'b0;
      end
      tcts_pkg::OP_P_POP: begin
        // The popped task walks back in from the tail unless it retires.
        nent        <= {cnt_sat, prd.level, prd.id};
        pwp         <= ptail;
        prem        <= pfill - 1'b1;
        res_code    <= tcts_pkg::EV_PRIO;
        res_id      <= prd.id;
        res_quanta  <= 6'd1;
        res_retired <= stat.retire;
      end
      tcts_pkg::OP_R_ROTATE: begin
        res_code    <= tcts_pkg::EV_RR;
        res_id      <= rrd;
        res_quanta  <= 6'd1;
        res_retired <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- design/tcts_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcts_ctrl
// Sequencer that walks the scheduler queues one entry at a time.
// ----------------------------------------------------------------------------
module tcts_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  input  tcts_pkg::stat_t stat,
  output tcts_pkg::op_t   op
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_PI_CHK = 4'd2;
  localparam logic [3:0] S_PI_CMP = 4'd3;
  localparam logic [3:0] S_SO_RD  = 4'd4;
  localparam logic [3:0] S_SO_CMP = 4'd5;
  localparam logic [3:0] S_SI_CHK = 4'd6;
  localparam logic [3:0] S_SI_CMP = 4'd7;
  localparam logic [3:0] S_ST_RD  = 4'd8;
  localparam logic [3:0] S_ST_CMP = 4'd9;
  localparam logic [3:0] S_TP     = 4'd10;
  localparam logic [3:0] S_TR     = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = tcts_pkg::OP_NOP;
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op         = tcts_pkg::OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.func == tcts_pkg::FN_TICK) begin
          op         = tcts_pkg::OP_SCAN_START;
          state_next = S_ST_RD;
        end else begin
          case (stat.cls)
            tcts_pkg::CLS_PRIO: begin
              if (stat.prio_full) begin
                op         = tcts_pkg::OP_RES_FULL;
                state_next = S_OUT;
              end else begin
                op         = tcts_pkg::OP_PI_START;
                state_next = S_PI_CHK;
              end
            end
            tcts_pkg::CLS_RR: begin
              op         = stat.rr_full ? tcts_pkg::OP_RES_FULL : tcts_pkg::OP_RR_APPEND;
              state_next = S_OUT;
            end
            tcts_pkg::CLS_RT: begin
              if (stat.window_bad) begin
                op         = tcts_pkg::OP_RES_WINDOW;
                state_next = S_OUT;
              end else begin
                op         = tcts_pkg::OP_SCAN_START;
                state_next = S_SO_RD;
              end
            end
            default: begin
              op         = tcts_pkg::OP_RES_IDLE;
              state_next = S_OUT;
            end
          endcase
        end
      end
      S_PI_CHK: begin
        if (stat.prem_zero) begin
          op         = tcts_pkg::OP_PI_PLACE;
          state_next = S_OUT;
        end else begin
          op         = tcts_pkg::OP_PI_READ;
          state_next = S_PI_CMP;
        end
      end
      S_PI_CMP: begin
        if (stat.level_gt) begin
          op         = tcts_pkg::OP_PI_SHIFT;
          state_next = S_PI_CHK;
        end else begin
          op         = tcts_pkg::OP_PI_PLACE;
          state_next = S_OUT;
        end
      end
      S_SO_RD: begin
        if (!stat.sidx_end) begin
          op         = tcts_pkg::OP_S_READ_K;
          state_next = S_SO_CMP;
        end else if (stat.slot_full) begin
          op         = tcts_pkg::OP_RES_FULL;
          state_next = S_OUT;
        end else begin
          op         = tcts_pkg::OP_SI_START;
          state_next = S_SI_CHK;
        end
      end
      S_SO_CMP: begin
        if (stat.overlap) begin
          op         = tcts_pkg::OP_RES_OVERLAP;
          state_next = S_OUT;
        end else begin
          op         = tcts_pkg::OP_K_INC;
          state_next = S_SO_RD;
        end
      end
      S_SI_CHK: begin
        if (stat.sidx_zero) begin
          op         = tcts_pkg::OP_SI_PLACE;
          state_next = S_OUT;
        end else begin
          op         = tcts_pkg::OP_SI_READ;
          state_next = S_SI_CMP;
        end
      end
      S_SI_CMP: begin
        if (stat.start_gt) begin
          op         = tcts_pkg::OP_SI_SHIFT;
          state_next = S_SI_CHK;
        end else begin
          op         = tcts_pkg::OP_SI_PLACE;
          state_next = S_OUT;
        end
      end
      S_ST_RD: begin
        if (!stat.sidx_end) begin
          op         = tcts_pkg::OP_S_READ_K;
          state_next = S_ST_CMP;
        end else if (!stat.prio_empty) begin
          op         = tcts_pkg::OP_P_READ_HEAD;
          state_next = S_TP;
        end else if (!stat.rr_empty) begin
          op         = tcts_pkg::OP_R_READ_HEAD;
          state_next = S_TR;
        end else begin
          op         = tcts_pkg::OP_RES_IDLE;
          state_next = S_OUT;
        end
      end
      S_ST_CMP: begin
        if (stat.slot_hit) begin
          op         = tcts_pkg::OP_RES_SLOT;
          state_next = S_OUT;
        end else begin
          op         = tcts_pkg::OP_K_INC;
          state_next = S_ST_RD;
        end
      end
      S_TP: begin
        op         = tcts_pkg::OP_P_POP;
        state_next = stat.retire ? S_OUT : S_PI_CHK;
      end
      S_TR: begin
        op         = tcts_pkg::OP_R_ROTATE;
        state_next = S_OUT;
      end
      S_OUT: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/three_class_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// three_class_task_scheduler
// Multilevel queue scheduler with priority, round-robin and real-time classes.
// ----------------------------------------------------------------------------
// Usage: a request on req either admits a task into its class queue or, as a
// tick, grants the next task; each request gives exactly one response on rsp.
// cfg writes the slot window (index 0) and the priority run limit (index 1);
// it is always ready and should be written only while no request is pending.
// One request is handled at a time: req is ready only when no request is in
// progress and no response is waiting, so a stalled rsp holds off new requests.
// The controller walks the queues one entry at a time: a priority admit walks
// the held tasks back from the tail, a slot admit scans every held slot for
// overlap and then moves later slots up, and a tick scans the slots and may
// reinsert a popped priority task. A round-robin admit, a window reject, a full
// priority or round-robin queue and an unused class walk no entries. req is
// ready again once the response has been taken.
// Reset empties all queues and restores the window to 60 and the limit to 3;
// no memory clearing pass is needed since only entries below a fill are read.
// ----------------------------------------------------------------------------
module three_class_task_scheduler #(
  parameter int PRIO_DEPTH = tcts_pkg::PRIO_DEPTH_DEF,
  parameter int RR_DEPTH   = tcts_pkg::RR_DEPTH_DEF,
  parameter int SLOT_DEPTH = tcts_pkg::SLOT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tcts_req_if.sink    req,
  tcts_rsp_if.source  rsp,
  tcts_cfg_if.sink    cfg
);

  tcts_pkg::op_t   op;
  tcts_pkg::stat_t stat;

  assign cfg.ready = 1'b1;

  tcts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .op        (op)
  );

  tcts_dpath #(
    .PRIO_DEPTH (PRIO_DEPTH),
    .RR_DEPTH   (RR_DEPTH),
    .SLOT_DEPTH (SLOT_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .stat        (stat),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .in_func     (req.func),
    .in_id       (req.task_id),
    .in_cls      (req.task_class),
    .in_level    (req.priority_level),
    .in_start    (req.start_second),
    .in_len      (req.run_length),
    .in_now      (req.current_second),
    .res_code    (rsp.event_code),
    .res_id      (rsp.run_task_id),
    .res_quanta  (rsp.run_quanta),
    .res_retired (rsp.task_retired)
  );

  a_no_overlap_req_rsp: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("request accepted while a response is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready && !rsp.valid)
    else $error("controller did not start work after a request");

  a_admit_fields_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.event_code == tcts_pkg::EV_ADMIT ||
                  rsp.event_code == tcts_pkg::EV_WINDOW ||
                  rsp.event_code == tcts_pkg::EV_OVERLAP ||
                  rsp.event_code == tcts_pkg::EV_FULL ||
                  rsp.event_code == tcts_pkg::EV_IDLE)
    |-> rsp.run_task_id == '0 && rsp.run_quanta == '0 && !rsp.task_retired)
    else $error("non-grant response carries grant fields");

  a_retire_is_prio: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.task_retired |-> rsp.event_code == tcts_pkg::EV_PRIO)
    else $error("retire flag on a non-priority grant");

endmodule

// ----- dv/tcts_sched_checker.sv -----
// ----------------------------------------------------------------------------
// tcts_sched_checker
// Watches the request, response and configuration channels of the scheduler,
// keeps its own copy of the three queues and compares every response.
// ----------------------------------------------------------------------------
module tcts_sched_checker (
  input  logic    clk,
  input  logic    rst,
  tcts_req_if     req,
  tcts_rsp_if     rsp,
  tcts_cfg_if     cfg,
  output int      fail_count,
  output int      pending
);

  typedef struct packed {
    logic [2:0]  code;
    logic [15:0] id;
    logic [5:0]  quanta;
    logic        retired;
  } grant_t;

  tcts_pkg::pent_t prio_q[$];
  logic [15:0]     rr_q[$];
  tcts_pkg::sent_t slot_q[$];
  logic [7:0]      window;
  logic [7:0]      run_limit;
  grant_t          grants_due[$];

  assign pending = grants_due.size();

  function automatic void prio_place(tcts_pkg::pent_t e);
    int pos;
    pos = 0;
    while (pos < prio_q.size() && prio_q[pos].level <= e.level) pos++;
    prio_q.insert(pos, e);
  endfunction

  function automatic grant_t schedule(logic fn, logic [15:0] id, logic [1:0] cls,
                                      logic [7:0] lvl, logic [5:0] st,
                                      logic [5:0] len, logic [5:0] now);
    grant_t          g;
    tcts_pkg::pent_t pe;
    tcts_pkg::sent_t se;
    int              pos;
    int              cnt;
    bit              hit;
    g = '0;
    hit = 0;
    if (fn == tcts_pkg::FN_ADMIT) begin
      if (cls == tcts_pkg::CLS_PRIO) begin
        if (prio_q.size() >= tcts_pkg::PRIO_DEPTH_DEF) g.code = tcts_pkg::EV_FULL;
        else begin
          pe.id = id; pe.level = lvl; pe.cnt = {2'b00, len};
          prio_place(pe);
          g.code = tcts_pkg::EV_ADMIT;
        end
      end else if (cls == tcts_pkg::CLS_RR) begin
        if (rr_q.size() >= tcts_pkg::RR_DEPTH_DEF) g.code = tcts_pkg::EV_FULL;
        else begin
          rr_q.push_back(id);
          g.code = tcts_pkg::EV_ADMIT;
        end
      end else if (cls == tcts_pkg::CLS_RT) begin
        if (int'(st) + int'(len) > int'(window)) g.code = tcts_pkg::EV_WINDOW;
        else begin
          foreach (slot_q[i])
            if (!(int'(st) + int'(len) <= int'(slot_q[i].start) ||
                  int'(slot_q[i].start) + int'(slot_q[i].len) <= int'(st)))
              hit = 1;
          if (hit) g.code = tcts_pkg::EV_OVERLAP;
          else if (slot_q.size() >= tcts_pkg::SLOT_DEPTH_DEF) g.code = tcts_pkg::EV_FULL;
          else begin
            pos = 0;
            while (pos < slot_q.size() && slot_q[pos].start <= st) pos++;
            se.id = id; se.start = st; se.len = len;
            slot_q.insert(pos, se);
            g.code = tcts_pkg::EV_ADMIT;
          end
        end
      end
    end else begin
      foreach (slot_q[i])
        if (!hit && slot_q[i].start == now) begin
          hit = 1;
          g.code = tcts_pkg::EV_RT; g.id = slot_q[i].id; g.quanta = slot_q[i].len;
        end
      if (!hit && prio_q.size() > 0) begin
        pe = prio_q.pop_front();
        cnt = int'(pe.cnt) + 1;
        if (cnt > 255) cnt = 255;
        g.code = tcts_pkg::EV_PRIO; g.id = pe.id; g.quanta = 6'd1;
        if (cnt >= int'(run_limit)) g.retired = 1'b1;
        else begin
          pe.cnt = cnt[7:0];
          prio_place(pe);
        end
      end else if (!hit && rr_q.size() > 0) begin
        g.code = tcts_pkg::EV_RR; g.id = rr_q[0]; g.quanta = 6'd1;
        rr_q.push_back(rr_q.pop_front());
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      prio_q.delete(); rr_q.delete(); slot_q.delete(); grants_due.delete();
      window <= tcts_pkg::WINDOW_RESET;
      run_limit <= tcts_pkg::LIMIT_RESET;
      fail_count <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == tcts_pkg::CFG_WINDOW) window <= cfg.data;
        else run_limit <= cfg.data;
      end
      if (req.valid && req.ready)
        grants_due.push_back(schedule(req.func, req.task_id, req.task_class,
                                      req.priority_level, req.start_second,
                                      req.run_length, req.current_second));
      if (rsp.valid && rsp.ready) begin
        if (grants_due.size() == 0) begin
          $error("response with no request outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = grants_due.pop_front();
          if (rsp.event_code !== want.code || rsp.run_task_id !== want.id ||
              rsp.run_quanta !== want.quanta || rsp.task_retired !== want.retired) begin
            if (rsp.event_code !== want.code)
              $error("event_code expected %0d got %0d", want.code, rsp.event_code);
            if (rsp.run_task_id !== want.id)
              $error("run_task_id expected %0d got %0d", want.id, rsp.run_task_id);
            if (rsp.run_quanta !== want.quanta)
              $error("run_quanta expected %0d got %0d", want.quanta, rsp.run_quanta);
            if (rsp.task_retired !== want.retired)
              $error("task_retired expected %0d got %0d", want.retired,
                     rsp.task_retired);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- dv/three_class_task_scheduler_tb.sv -----
// ----------------------------------------------------------------------------
// three_class_task_scheduler_tb
// Drives admits and ticks with random gaps and response stalls across several
// window and run limit settings; the checker predicts and compares responses.
// ----------------------------------------------------------------------------
module three_class_task_scheduler_tb;

  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   quiet_cycles;

  tcts_req_if req ();
  tcts_rsp_if rsp ();
  tcts_cfg_if cfg ();

  three_class_task_scheduler i_dut (
    .clk (clk), .rst (rst), .req (req), .rsp (rsp), .cfg (cfg)
  );

  tcts_sched_checker i_checker (
    .clk (clk), .rst (rst), .req (req), .rsp (rsp), .cfg (cfg),
    .fail_count (fail_count), .pending (pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Response stalls of random length, mostly short with a few long ones.
  initial begin
    int g;
    rsp.ready = 1'b0;
    forever begin
      g = gap_len();
      if (g > 0) begin
        rsp.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog on cycles without any accepted request or response.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Valid stays high after an accept so that requests can follow back to back;
  // it is dropped at the start of a gap or by idle_req.
  task automatic send(logic fn, logic [15:0] id, logic [1:0] cls, logic [7:0] lvl,
                      logic [5:0] st, logic [5:0] len, logic [5:0] now);
    int g;
    g = gap_len();
    if (g > 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func <= fn;
    req.task_id <= id;
    req.task_class <= cls;
    req.priority_level <= lvl;
    req.start_second <= st;
    req.run_length <= len;
    req.current_second <= now;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic idle_req();
    req.valid <= 1'b0;
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    idle_req();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic random_item();
    int         r;
    logic [1:0] cls;
    logic [7:0] lvl;
    logic [5:0] st;
    logic [5:0] len;
    logic [5:0] now;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      now = ($urandom_range(0, 99) < 50) ? 6'($urandom_range(0, 60))
                                         : 6'($urandom_range(0, 63));
      send(tcts_pkg::FN_TICK, 16'($urandom), 2'($urandom), 8'($urandom),
           6'($urandom), 6'($urandom), now);
    end else begin
      cls = (r < 38) ? tcts_pkg::CLS_UNUSED : 2'($urandom_range(0, 2));
      lvl = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      st  = 6'($urandom_range(0, 63));
      len = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63))
                                        : 6'($urandom_range(0, 6));
      send(tcts_pkg::FN_ADMIT, 16'($urandom), cls, lvl, st, len, 6'($urandom));
    end
  endtask

  initial begin
    logic [7:0] windows[4];
    logic [7:0] limits[4];
    req.valid = 0; req.func = 0; req.task_id = 0; req.task_class = 0;
    req.priority_level = 0; req.start_second = 0; req.run_length = 0;
    req.current_second = 0;
    cfg.valid = 0; cfg.index = 0; cfg.data = 0;
    rst = 1;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, each class, rejects, unused class, idle tick.
    send(tcts_pkg::FN_TICK, 16'hFFFF, tcts_pkg::CLS_PRIO, 8'hFF, 6'h3F, 6'h3F, 6'd0);
    send(tcts_pkg::FN_ADMIT, 16'hFFFF, tcts_pkg::CLS_PRIO, 8'hFF, 6'h3F, 6'h3F, 6'h3F);
    send(tcts_pkg::FN_ADMIT, 16'h0001, tcts_pkg::CLS_PRIO, 8'h00, 6'd0, 6'd0, 6'd0);
    send(tcts_pkg::FN_ADMIT, 16'h0002, tcts_pkg::CLS_PRIO, 8'h00, 6'd0, 6'd5, 6'd0);
    send(tcts_pkg::FN_ADMIT, 16'hAAAA, tcts_pkg::CLS_RR, 8'h00, 6'd0, 6'd0, 6'd0);
    send(tcts_pkg::FN_ADMIT, 16'h5555, tcts_pkg::CLS_UNUSED, 8'hFF, 6'h3F, 6'h3F, 6'h3F);
    send(tcts_pkg::FN_ADMIT, 16'h0010, tcts_pkg::CLS_RT, 8'h00, 6'd10, 6'd5, 6'd0);
    send(tcts_pkg::FN_ADMIT, 16'h0011, tcts_pkg::CLS_RT, 8'h00, 6'd14, 6'd3, 6'd0);
    send(tcts_pkg::FN_ADMIT, 16'h0012, tcts_pkg::CLS_RT, 8'h00, 6'd15, 6'd0, 6'd0);
    send(tcts_pkg::FN_ADMIT, 16'h0013, tcts_pkg::CLS_RT, 8'h00, 6'd55, 6'd5, 6'd0);
    send(tcts_pkg::FN_ADMIT, 16'h0014, tcts_pkg::CLS_RT, 8'h00, 6'd56, 6'd5, 6'd0);
    send(tcts_pkg::FN_ADMIT, 16'h0015, tcts_pkg::CLS_RT, 8'h00, 6'h3F, 6'h3F, 6'd0);
    send(tcts_pkg::FN_TICK, 16'h0, tcts_pkg::CLS_PRIO, 8'h0, 6'd0, 6'd0, 6'd10);
    send(tcts_pkg::FN_TICK, 16'h0, tcts_pkg::CLS_PRIO, 8'h0, 6'd0, 6'd0, 6'd60);
    repeat (6) send(tcts_pkg::FN_TICK, 16'h0, tcts_pkg::CLS_PRIO, 8'h0, 6'd0, 6'd0, 6'd1);
    for (int i = 0; i < 17; i++)
      send(tcts_pkg::FN_ADMIT, 16'(i), tcts_pkg::CLS_RR, 8'h0, 6'd0, 6'd0, 6'd0);

    windows = '{8'd255, 8'd1, 8'd30, 8'd60};
    limits  = '{8'd255, 8'd1, 8'd2, 8'd3};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(tcts_pkg::CFG_WINDOW, windows[ph]);
      write_reg(tcts_pkg::CFG_LIMIT, limits[ph]);
      for (int n = 0; n < 500; n++) random_item();
    end

    idle_req();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
